// ===== rtl/lpt_pkg.sv =====
// Shared widths, register defaults, register indexes and result type of the lane tracker.
package lpt_pkg;

    localparam int WeightW    = 16;
    localparam int SlopeW     = 24;
    localparam int InterceptW = 32;
    localparam int LostW      = 8;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 31;

    localparam logic [WeightW-1:0]    WeightReset        = 16'd45875;
    localparam logic [SlopeW-2:0]     SlopeGateReset     = 23'd8192;
    localparam logic [InterceptW-2:0] InterceptGateReset = 31'd25600;
    localparam logic [LostW-1:0]      LostLimitReset     = 8'd10;
    localparam logic [LostW-1:0]      LostMax            = 8'd255;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_WEIGHT         = 2'd0,
        CFG_SLOPE_GATE     = 2'd1,
        CFG_INTERCEPT_GATE = 2'd2,
        CFG_LOST_LIMIT     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                         found;
        logic signed [SlopeW-1:0]     slope;
        logic signed [InterceptW-1:0] intercept;
        logic                         in_reset;
        logic [LostW-1:0]             lost;
    } t_result;

endpackage

// ===== rtl/lpt_ema.sv =====
// Gate check and one rounded moving-average update for a single line parameter.
module lpt_ema #(
    parameter int W = lpt_pkg::SlopeW
) (
    input  logic [W-1:0]                 i_avg,
    input  logic [W-1:0]                 i_sample,
    input  logic [W-2:0]                 i_gate,
    input  logic [lpt_pkg::WeightW-1:0]  i_weight,
    input  logic                         i_unseeded,
    output logic                         o_within,
    output logic [W-1:0]                 o_next_avg
);

    localparam int PW = W + lpt_pkg::WeightW + 2;
    localparam logic signed [PW-1:0] RoundBias = PW'(1) <<< (lpt_pkg::WeightW - 1);

    logic signed [W:0]    w_diff;
    logic        [W:0]    w_mag;
    logic signed [W:0]    w_step_diff;
    logic        [W-1:0]  w_base;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_round;
    logic signed [PW-1:0] w_delta;

    // difference is exact one bit wider than the field
    assign w_diff = $signed({i_sample[W-1], i_sample}) - $signed({i_avg[W-1], i_avg});
    assign w_mag  = w_diff[W] ? (W+1)'(-w_diff) : w_diff;
    assign o_within = (w_mag <= {2'b00, i_gate});

    // an unseeded average is first loaded with the sample, so the step is zero
    assign w_step_diff = i_unseeded ? '0 : w_diff;
    assign w_base      = i_unseeded ? i_sample : i_avg;

    assign w_prod  = $signed({1'b0, i_weight}) * w_step_diff;
    assign w_round = w_prod + RoundBias;
    assign w_delta = w_round >>> lpt_pkg::WeightW;

    assign o_next_avg = w_base + w_delta[W-1:0];

endmodule

// ===== rtl/lane_parameter_tracker_unit.sv =====
// Top level of the lane parameter tracker: gated moving averages of slope and intercept.
// Flow: an accepted item sits in the input register, then its result is written into the
//   result queue, whose front entry drives the outputs until downstream takes it.
// Throughput: one item per cycle while the result queue has room; the state loop (subtract,
//   multiply, round, add) is combinational between the input register and the tracking state.
// Reset (i_rst_n low, synchronous): config registers return to their defaults, the averages
//   clear to zero, tracking re-enters reset unseeded, the lost count clears, queues empty.
module lane_parameter_tracker_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_candidate_found,
    input  logic signed [lpt_pkg::SlopeW-1:0]      i_candidate_slope,
    input  logic signed [lpt_pkg::InterceptW-1:0]  i_candidate_intercept,
    // config write port
    input  logic                                   i_cfg_we,
    input  logic [lpt_pkg::CfgIndexW-1:0]          i_cfg_index,
    input  logic [lpt_pkg::CfgDataW-1:0]           i_cfg_data,
    // result item channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_side_found,
    output logic signed [lpt_pkg::SlopeW-1:0]      o_slope_average,
    output logic signed [lpt_pkg::InterceptW-1:0]  o_intercept_average,
    output logic                                   o_in_reset,
    output logic [lpt_pkg::LostW-1:0]              o_lost_frames
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [lpt_pkg::WeightW-1:0]    r_weight;
    logic [lpt_pkg::SlopeW-2:0]     r_slope_gate;
    logic [lpt_pkg::InterceptW-2:0] r_icpt_gate;
    logic [lpt_pkg::LostW-1:0]      r_lost_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight     <= lpt_pkg::WeightReset;
            r_slope_gate <= lpt_pkg::SlopeGateReset;
            r_icpt_gate  <= lpt_pkg::InterceptGateReset;
            r_lost_limit <= lpt_pkg::LostLimitReset;
        end else if (i_cfg_we) begin
            case (lpt_pkg::t_cfg_reg'(i_cfg_index))
                lpt_pkg::CFG_WEIGHT:         r_weight     <= i_cfg_data[lpt_pkg::WeightW-1:0];
                lpt_pkg::CFG_SLOPE_GATE:     r_slope_gate <= i_cfg_data[lpt_pkg::SlopeW-2:0];
                lpt_pkg::CFG_INTERCEPT_GATE: r_icpt_gate  <= i_cfg_data[lpt_pkg::InterceptW-2:0];
                lpt_pkg::CFG_LOST_LIMIT:     r_lost_limit <= i_cfg_data[lpt_pkg::LostW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and two-entry result queue (result register + skid)
    // ------------------------------------------------------------------
    logic                                  r_in_valid;
    logic                                  r_in_found;
    logic [lpt_pkg::SlopeW-1:0]            r_in_slope;
    logic [lpt_pkg::InterceptW-1:0]        r_in_icpt;

    lpt_pkg::t_result r_out, r_skid, n_out, n_skid, n_result;
    logic             r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;

    logic w_full;   // both result entries occupied
    logic w_step;   // the held item is processed this cycle
    logic w_pop;    // downstream takes the front result

    assign w_full  = r_out_valid & r_skid_valid;
    assign w_step  = r_in_valid & ~w_full;
    assign w_pop   = r_out_valid & ~i_stall;
    assign o_stall = r_in_valid & w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_found <= i_candidate_found;
            r_in_slope <= i_candidate_slope;
            r_in_icpt  <= i_candidate_intercept;
        end
    end

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    logic [lpt_pkg::SlopeW-1:0]     r_avg_slope, n_avg_slope;
    logic [lpt_pkg::InterceptW-1:0] r_avg_icpt,  n_avg_icpt;
    logic                           r_unseeded,  n_unseeded;
    logic                           r_trk_reset, n_trk_reset;
    logic [lpt_pkg::LostW-1:0]      r_lost,      n_lost;

    logic                           w_slope_within, w_icpt_within;
    logic [lpt_pkg::SlopeW-1:0]     w_slope_next;
    logic [lpt_pkg::InterceptW-1:0] w_icpt_next;
    logic                           w_take;
    logic [lpt_pkg::LostW-1:0]      w_lost_inc;
    logic                           w_at_limit;

    lpt_ema #(
        .W (lpt_pkg::SlopeW)
    ) u_ema_slope (
        .i_avg      (r_avg_slope),
        .i_sample   (r_in_slope),
        .i_gate     (r_slope_gate),
        .i_weight   (r_weight),
        .i_unseeded (r_unseeded),
        .o_within   (w_slope_within),
        .o_next_avg (w_slope_next)
    );

    lpt_ema #(
        .W (lpt_pkg::InterceptW)
    ) u_ema_icpt (
        .i_avg      (r_avg_icpt),
        .i_sample   (r_in_icpt),
        .i_gate     (r_icpt_gate),
        .i_weight   (r_weight),
        .i_unseeded (r_unseeded),
        .o_within   (w_icpt_within),
        .o_next_avg (w_icpt_next)
    );

    // accept inside both gates, or anything while tracking is in reset
    assign w_take     = (w_slope_within & w_icpt_within) | r_trk_reset;
    // saturate the lost count at its top value
    assign w_lost_inc = (r_lost == lpt_pkg::LostMax) ? r_lost : r_lost + 1'b1;
    assign w_at_limit = (w_lost_inc >= r_lost_limit);

    always_comb begin
        n_avg_slope = r_avg_slope;
        n_avg_icpt  = r_avg_icpt;
        n_unseeded  = r_unseeded;
        n_trk_reset = r_trk_reset;
        n_lost      = r_lost;
        if (w_step) begin
            if (r_in_found) begin
                if (w_take) begin
                    n_avg_slope = w_slope_next;
                    n_avg_icpt  = w_icpt_next;
                    n_unseeded  = 1'b0;
                    n_trk_reset = 1'b0;
                    n_lost      = '0;
                end else begin
                    n_lost = w_lost_inc;
                    if (w_at_limit) begin
                        n_trk_reset = 1'b1;
                    end
                end
            end else begin
                // missing candidate: entering reset also drops the seed
                n_lost = w_lost_inc;
                if (w_at_limit && !r_trk_reset) begin
                    n_trk_reset = 1'b1;
                    n_unseeded  = 1'b1;
                end
            end
        end
        n_result.found     = r_in_found;
        n_result.slope     = n_avg_slope;
        n_result.intercept = n_avg_icpt;
        n_result.in_reset  = n_trk_reset;
        n_result.lost      = n_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_slope <= '0;
            r_avg_icpt  <= '0;
            r_unseeded  <= 1'b1;
            r_trk_reset <= 1'b1;
            r_lost      <= '0;
        end else begin
            r_avg_slope <= n_avg_slope;
            r_avg_icpt  <= n_avg_icpt;
            r_unseeded  <= n_unseeded;
            r_trk_reset <= n_trk_reset;
            r_lost      <= n_lost;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: front entry drives the ports, skid catches the item
    // finished while the front one is stalled
    // ------------------------------------------------------------------
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_step) begin
            if (!n_out_valid) begin
                n_out       = n_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = n_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid             = r_out_valid;
    assign o_side_found        = r_out.found;
    assign o_slope_average     = r_out.slope;
    assign o_intercept_average = r_out.intercept;
    assign o_in_reset          = r_out.in_reset;
    assign o_lost_frames       = r_out.lost;

endmodule

// ===== rtl/lpt_checker.sv =====
// Port-level checks for the lane parameter tracker, bound to the top level.
module lpt_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic                                  o_side_found,
    input logic signed [lpt_pkg::SlopeW-1:0]     o_slope_average,
    input logic signed [lpt_pkg::InterceptW-1:0] o_intercept_average,
    input logic                                  o_in_reset,
    input logic [lpt_pkg::LostW-1:0]             o_lost_frames
);

    // hold a stalled result unchanged
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_side_found) &&
            $stable(o_slope_average) && $stable(o_intercept_average) &&
            $stable(o_in_reset) && $stable(o_lost_frames))
        else $error("stalled result changed");

    // a missing candidate always counts a lost frame
    a_missing_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_side_found |-> o_lost_frames != '0)
        else $error("missing candidate left lost count at zero");

    // a found candidate with zero lost frames was taken, so tracking left reset
    a_taken_leaves_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_side_found && o_lost_frames == '0 |-> !o_in_reset)
        else $error("taken candidate still reports reset");

    // drop every result on reset
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind lane_parameter_tracker_unit lpt_checker u_lpt_checker (.*);
